// ===== hdl/hsl_to_rgb_converter_macros.svh =====
// Assertion macros for the HSL to RGB converter.
// Included by the converter RTL files; no other dependencies.
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
`define H2R_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hsl2rgb: assertion failed");
`define H2R_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("hsl2rgb: forbidden condition seen");
`else
`define H2R_ASSERT(lbl, clk, rstn, prop)
`define H2R_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hdl/hsl2rgb_pkg.sv =====
// Shared constants, types and the divide-by-full-scale helper of the
// HSL to RGB converter. No dependencies.
package hsl2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * FRAC_BITS + 1;
    localparam int N_LANES   = 3;
    localparam int N_STAGES  = 8;

    localparam logic [FRAC_BITS-1:0] SCALE      = {FRAC_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0] HALF_SCALE = SCALE >> 1;

    typedef struct packed {
        logic [N_STAGES-1:0] en;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] hue;
        logic [FRAC_BITS-1:0] q;
        logic [FRAC_BITS-1:0] p;
        logic [FRAC_BITS-1:0] d;
        logic [FRAC_BITS-1:0] lightness;
        logic                 grey;
    } lq_res_t;

    // floor(num / SCALE) for num < SCALE * (SCALE + 2): estimate by the high
    // half, then one correction step.
    function automatic logic [FRAC_BITS:0] div_scale(input logic [PROD_BITS-1:0] num);
        logic [FRAC_BITS:0]   est;
        logic [FRAC_BITS+1:0] rem;
        est = num[PROD_BITS-1:FRAC_BITS];
        rem = {2'b00, num[FRAC_BITS-1:0]} + {1'b0, est};
        if (rem >= {2'b00, SCALE}) begin
            return est + {{FRAC_BITS{1'b0}}, 1'b1};
        end
        return est;
    endfunction

endpackage

// ===== hdl/hsl2rgb_lq.sv =====
// Stages 0 to 4 of the converter: forms q and p from lightness and saturation.
// Depends on hsl2rgb_pkg and the assertion macro header.
`include "hsl_to_rgb_converter_macros.svh"

module hsl2rgb_lq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hsl2rgb_pkg::pipe_ctrl_t             ctrl,
    input  logic [hsl2rgb_pkg::FRAC_BITS-1:0]   hue,
    input  logic [hsl2rgb_pkg::FRAC_BITS-1:0]   saturation,
    input  logic [hsl2rgb_pkg::FRAC_BITS-1:0]   lightness,
    output hsl2rgb_pkg::lq_res_t                res
);
    localparam int FB = hsl2rgb_pkg::FRAC_BITS;
    localparam int PB = hsl2rgb_pkg::PROD_BITS;
    localparam logic [FB-1:0] SCALE = hsl2rgb_pkg::SCALE;

    // stage 0
    logic [FB:0]     m0_reg, m0_next;
    logic [2*FB-1:0] add0_reg, add0_next;
    logic [FB-1:0]   l0_reg, h0_reg;
    logic            grey0_reg;
    // stage 1
    logic [PB-1:0]   prod1_reg, prod1_next;
    logic [2*FB-1:0] add1_reg;
    logic [FB-1:0]   l1_reg, h1_reg;
    logic            grey1_reg;
    // stage 2
    logic [PB-1:0]   x2_reg, x2_next;
    logic [FB-1:0]   l2_reg, h2_reg;
    logic            grey2_reg;
    // stage 3
    logic [FB-1:0]   q3_reg, q3_next;
    logic [FB-1:0]   l3_reg, h3_reg;
    logic            grey3_reg;
    // stage 4
    logic [FB-1:0]   q4_reg, q4_next, p4_reg, p4_next, d4_reg, d4_next, l4_reg;
    logic            grey4_reg;

    logic            low_half;
    logic [FB:0]     q3_full;
    logic [FB:0]     two_l;
    logic [FB-1:0]   qc;
    logic [FB:0]     p_wide;

    always_comb begin
        // q2 = l * m + add; below half lightness add is zero
        low_half = ({1'b0, lightness} << 1) < {1'b0, SCALE};
        if (low_half) begin
            m0_next   = {1'b0, SCALE} + {1'b0, saturation};
            add0_next = '0;
        end else begin
            m0_next   = {1'b0, SCALE} - {1'b0, saturation};
            add0_next = {saturation, {FB{1'b0}}} - {{FB{1'b0}}, saturation};
        end

        prod1_next = {{(PB-FB){1'b0}}, l0_reg} * {{(PB-FB-1){1'b0}}, m0_reg};
        x2_next    = prod1_reg + {1'b0, add1_reg}
                   + {{(PB-FB){1'b0}}, hsl2rgb_pkg::HALF_SCALE};

        q3_full = hsl2rgb_pkg::div_scale(x2_reg);
        q3_next = (q3_full > {1'b0, SCALE}) ? SCALE : q3_full[FB-1:0];

        qc     = (q3_reg < l3_reg) ? l3_reg : q3_reg;
        two_l  = {l3_reg, 1'b0};
        p_wide = (two_l >= {1'b0, qc}) ? (two_l - {1'b0, qc}) : '0;
        p4_next = (p_wide > {1'b0, qc}) ? qc : p_wide[FB-1:0];
        q4_next = qc;
        d4_next = qc - p4_next;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            m0_reg    <= m0_next;
            add0_reg  <= add0_next;
            l0_reg    <= lightness;
            h0_reg    <= hue;
            grey0_reg <= (saturation == '0);
        end
        if (ctrl.en[1]) begin
            prod1_reg <= prod1_next;
            add1_reg  <= add0_reg;
            l1_reg    <= l0_reg;
            h1_reg    <= h0_reg;
            grey1_reg <= grey0_reg;
        end
        if (ctrl.en[2]) begin
            x2_reg    <= x2_next;
            l2_reg    <= l1_reg;
            h2_reg    <= h1_reg;
            grey2_reg <= grey1_reg;
        end
        if (ctrl.en[3]) begin
            q3_reg    <= q3_next;
            l3_reg    <= l2_reg;
            h3_reg    <= h2_reg;
            grey3_reg <= grey2_reg;
        end
        if (ctrl.en[4]) begin
            q4_reg    <= q4_next;
            p4_reg    <= p4_next;
            d4_reg    <= d4_next;
            l4_reg    <= l3_reg;
            grey4_reg <= grey3_reg;
        end
    end

    assign res.hue       = h3_reg;
    assign res.q         = q4_reg;
    assign res.p         = p4_reg;
    assign res.d         = d4_reg;
    assign res.lightness = l4_reg;
    assign res.grey      = grey4_reg;

    `H2R_ASSERT(a_lq_p_le_q, aclk, aresetn, $rose(ctrl.en[4]) |=> (p4_reg <= q4_reg))
    `H2R_ASSERT(a_lq_d_span, aclk, aresetn, ##1 $past(ctrl.en[4]) |-> (d4_reg + p4_reg == q4_reg))

endmodule

// ===== hdl/hsl2rgb_ramp.sv =====
// Stages 4 to 7 of the converter: hue offset and wrap, ramp scaling per channel,
// output selection. Depends on hsl2rgb_pkg and the assertion macro header.
`include "hsl_to_rgb_converter_macros.svh"

module hsl2rgb_ramp (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  hsl2rgb_pkg::pipe_ctrl_t                       ctrl,
    input  hsl2rgb_pkg::lq_res_t                          lq,
    output logic [hsl2rgb_pkg::N_LANES-1:0][hsl2rgb_pkg::FRAC_BITS-1:0] chan
);
    localparam int FB = hsl2rgb_pkg::FRAC_BITS;
    localparam int PB = hsl2rgb_pkg::PROD_BITS;
    localparam int NL = hsl2rgb_pkg::N_LANES;
    localparam int TW = FB + 4;
    localparam logic [FB-1:0] SCALE = hsl2rgb_pkg::SCALE;
    localparam logic signed [TW-1:0] SC_S    = TW'(SCALE);
    localparam logic signed [TW-1:0] FULL_S  = TW'(3) * SC_S;
    localparam logic signed [TW-1:0] TWO_S   = TW'(2) * SC_S;
    // red leads by a third of the circle, blue lags by a third
    localparam logic signed [TW-1:0] HUE_OFFSET [NL] = '{SC_S, '0, -SC_S};

    typedef enum logic [1:0] {SEG_RISE, SEG_FLAT, SEG_FALL, SEG_LOW} seg_t;

    seg_t            seg4_reg [NL], seg4_next [NL];
    logic [FB-1:0]   x4_reg [NL], x4_next [NL];

    logic [2*FB-1:0] prod5_reg [NL], prod5_next [NL];
    seg_t            seg5_reg [NL];
    logic [FB-1:0]   p5_reg, q5_reg, l5_reg;
    logic            grey5_reg;

    logic [FB:0]     quot6_reg [NL], quot6_next [NL];
    seg_t            seg6_reg [NL];
    logic [FB-1:0]   p6_reg, q6_reg, l6_reg;
    logic            grey6_reg;

    logic [FB-1:0]   chan_reg [NL], chan_next [NL];

    logic signed [TW-1:0] th;
    logic signed [TW-1:0] t [NL];
    logic [FB+1:0]        sum [NL];

    always_comb begin
        th = TW'({lq.hue, 1'b0}) + TW'(lq.hue);
        for (int i = 0; i < NL; i++) begin
            t[i] = th + HUE_OFFSET[i];
            if (t[i] < 0) begin
                t[i] = t[i] + FULL_S;
            end else if (t[i] > FULL_S) begin
                t[i] = t[i] - FULL_S;
            end
            x4_next[i] = '0;
            if ((t[i] <<< 1) < SC_S) begin
                seg4_next[i] = SEG_RISE;
                x4_next[i]   = FB'(t[i] <<< 1);
            end else if ((t[i] <<< 1) < FULL_S) begin
                seg4_next[i] = SEG_FLAT;
            end else if (t[i] < TWO_S) begin
                seg4_next[i] = SEG_FALL;
                x4_next[i]   = FB'((TWO_S - t[i]) <<< 1);
            end else begin
                seg4_next[i] = SEG_LOW;
            end

            prod5_next[i] = lq.d * x4_reg[i];
            quot6_next[i] = hsl2rgb_pkg::div_scale({1'b0, prod5_reg[i]}
                          + {{(PB-FB){1'b0}}, hsl2rgb_pkg::HALF_SCALE});

            sum[i] = {2'b00, p6_reg} + {1'b0, quot6_reg[i]};
            case (seg6_reg[i]) inside
                SEG_RISE, SEG_FALL:
                    chan_next[i] = (sum[i] > {2'b00, SCALE}) ? SCALE : sum[i][FB-1:0];
                SEG_FLAT: chan_next[i] = q6_reg;
                default:  chan_next[i] = p6_reg;
            endcase
            if (grey6_reg) begin
                chan_next[i] = l6_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) begin
            seg4_reg <= seg4_next;
            x4_reg   <= x4_next;
        end
        if (ctrl.en[5]) begin
            prod5_reg <= prod5_next;
            seg5_reg  <= seg4_reg;
            p5_reg    <= lq.p;
            q5_reg    <= lq.q;
            l5_reg    <= lq.lightness;
            grey5_reg <= lq.grey;
        end
        if (ctrl.en[6]) begin
            quot6_reg <= quot6_next;
            seg6_reg  <= seg5_reg;
            p6_reg    <= p5_reg;
            q6_reg    <= q5_reg;
            l6_reg    <= l5_reg;
            grey6_reg <= grey5_reg;
        end
        if (ctrl.en[7]) begin
            chan_reg <= chan_next;
        end
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            chan[i] = chan_reg[i];
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_chk
        `H2R_ASSERT(a_rise_below_scale, aclk, aresetn, (seg4_reg[g] == SEG_RISE) |-> (x4_reg[g] < SCALE))
        `H2R_ASSERT(a_flat_no_slope, aclk, aresetn, (seg4_reg[g] == SEG_FLAT || seg4_reg[g] == SEG_LOW) |-> (x4_reg[g] == '0))
    end

endmodule

// ===== hdl/hsl_to_rgb_converter.sv =====
// HSL to RGB converter: an eight-stage pipeline that takes one colour per clock
// while the master side is not stalled. A colour accepted on the slave side
// passes through stages 0 to 7 to the master side; throughput is one colour per
// cycle, with one multiplier in the q path and one in each channel ramp.
// Every stage holds its own valid bit, so a stall on the master side only stops
// the input once all eight stages are full; empty stages keep filling meanwhile.
// Depends on hsl2rgb_pkg, hsl2rgb_lq, hsl2rgb_ramp and the assertion macro header.
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] hue, [31:16] saturation, [47:32] lightness
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] red, [31:16] green, [47:32] blue
);
    localparam int FB = hsl2rgb_pkg::FRAC_BITS;
    localparam int NS = hsl2rgb_pkg::N_STAGES;
    localparam int NL = hsl2rgb_pkg::N_LANES;

    logic [NS-1:0]            valid_reg, valid_next;
    logic [NS:0]              ready;
    hsl2rgb_pkg::pipe_ctrl_t  ctrl;
    hsl2rgb_pkg::lq_res_t     lq_res;
    logic [NL-1:0][FB-1:0]    chan;

    // a stage advances when it is empty or the stage after it advances
    always_comb begin
        ready[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = ~valid_reg[k] | ready[k+1];
        end
        ctrl.en = ready[NS-1:0];
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++) begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    hsl2rgb_lq u_lq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .hue        (s_tdata[15:0]),
        .saturation (s_tdata[31:16]),
        .lightness  (s_tdata[47:32]),
        .res        (lq_res)
    );

    hsl2rgb_ramp u_ramp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .lq      (lq_res),
        .chan    (chan)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {chan[2], chan[1], chan[0]};

    `H2R_ASSERT(a_empty_out_takes_input, aclk, aresetn, !m_tvalid |-> s_tready)
    `H2R_ASSERT(a_full_stall_blocks, aclk, aresetn, ((&valid_reg) && !m_tready) |-> !s_tready)

endmodule

// ===== bench/hsl_to_rgb_converter_tb.sv =====
// Self-checking bench for hsl_to_rgb_converter: drives colour transfers under
// several idle/stall mixes and checks every RGB result against its own model.
// Depends on hsl2rgb_pkg and the hsl_to_rgb_converter RTL.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;

    localparam int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS;

    localparam longint unsigned FULL_CODE   = (64'd1 << FRAC_BITS) - 64'd1;
    localparam longint unsigned HALF_CODE   = FULL_CODE >> 1;
    localparam int              RESET_CYCLES = 7;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              STALL_LIMIT  = 2000;
    localparam int              DRAIN_CYCLES = 20;
    localparam int              PHASE_ITEMS  = 372;
    localparam int              BURST_ITEMS  = 40;

    typedef struct packed {
        logic [FRAC_BITS-1:0] lightness;
        logic [FRAC_BITS-1:0] saturation;
        logic [FRAC_BITS-1:0] hue;
    } hsl_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] blue;
        logic [FRAC_BITS-1:0] green;
        logic [FRAC_BITS-1:0] red;
    } rgb_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    class rgb_scoreboard;
        rgb_t        expected_rgb_q[$];
        hsl_t        source_hsl_q[$];
        int unsigned mismatches;

        // One channel of the hue ramp; t is hue at three times full scale.
        static function logic [FRAC_BITS-1:0] ramp_level(longint unsigned p,
                                                         longint unsigned q,
                                                         longint t);
            longint          span3;
            longint          span1;
            longint unsigned d;
            longint unsigned x;
            longint unsigned v;
            span3 = 3 * longint'(FULL_CODE);
            span1 = longint'(FULL_CODE);
            d = q - p;
            if (t < 0) t += span3;
            if (t > span3) t -= span3;
            if (2 * t < span1) begin
                x = 2 * t;
                v = p + (d * x + HALF_CODE) / FULL_CODE;
            end else if (2 * t < span3) begin
                v = q;
            end else if (t < 2 * span1) begin
                x = 2 * (2 * span1 - t);
                v = p + (d * x + HALF_CODE) / FULL_CODE;
            end else begin
                v = p;
            end
            if (v > FULL_CODE) v = FULL_CODE;
            return v[FRAC_BITS-1:0];
        endfunction

        static function rgb_t hsl_to_rgb(hsl_t c);
            rgb_t            r;
            longint unsigned h;
            longint unsigned s;
            longint unsigned l;
            longint unsigned q2;
            longint unsigned q;
            longint unsigned p;
            longint          th;
            h = c.hue;
            s = c.saturation;
            l = c.lightness;
            if (s == 0) begin
                r.red   = c.lightness;
                r.green = c.lightness;
                r.blue  = c.lightness;
                return r;
            end
            if (2 * l < FULL_CODE) q2 = l * (FULL_CODE + s);
            else q2 = l * FULL_CODE + s * FULL_CODE - l * s;
            q = (q2 + HALF_CODE) / FULL_CODE;
            if (q > FULL_CODE) q = FULL_CODE;
            if (q < l) q = l;
            p = (2 * l >= q) ? (2 * l - q) : 0;
            if (p > q) p = q;
            th = 3 * longint'(h);
            r.red   = ramp_level(p, q, th + longint'(FULL_CODE));
            r.green = ramp_level(p, q, th);
            r.blue  = ramp_level(p, q, th - longint'(FULL_CODE));
            return r;
        endfunction

        function void note_colour(hsl_t c);
            source_hsl_q.push_back(c);
            expected_rgb_q.push_back(hsl_to_rgb(c));
        endfunction

        function void check_colour(rgb_t got);
            rgb_t want;
            hsl_t src;
            if (expected_rgb_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue);
                return;
            end
            want = expected_rgb_q.pop_front();
            src  = source_hsl_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch h=%0d s=%0d l=%0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             src.hue, src.saturation, src.lightness,
                             want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return expected_rgb_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [15:0] hue, [31:16] saturation, [47:32] lightness
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [15:0] red, [31:16] green, [47:32] blue

    rgb_scoreboard colour_sb = new();
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_request = 1'b0;
    int            quiet_cycles = 0;

    hsl_to_rgb_converter u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Record transfers on both sides and watch for a hung pipeline.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) colour_sb.note_colour(hsl_t'(s_tdata));
            if (m_tvalid && m_tready) colour_sb.check_colour(rgb_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_colour(input hsl_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (colour_sb.pending() != 0);
    endtask

    function automatic hsl_t random_colour();
        hsl_t c;
        logic [FRAC_BITS-1:0] hue_corner[8] = '{16'd0, 16'd65535, 16'd21844, 16'd21845,
                                                 16'd43690, 16'd43691, 16'd10922, 16'd32768};
        logic [FRAC_BITS-1:0] light_corner[6] = '{16'd0, 16'd1, 16'd32767, 16'd32768,
                                                   16'd65534, 16'd65535};
        c.hue        = ($urandom_range(7) == 0) ? hue_corner[$urandom_range(7)]
                                                : FRAC_BITS'($urandom);
        c.lightness  = ($urandom_range(7) == 0) ? light_corner[$urandom_range(5)]
                                                : FRAC_BITS'($urandom);
        case ($urandom_range(15))
            0, 1: c.saturation = '0;
            2:    c.saturation = '1;
            3:    c.saturation = FRAC_BITS'($urandom_range(1, 3));
            default: c.saturation = FRAC_BITS'($urandom);
        endcase
        return c;
    endfunction

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 75;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 75;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
        endcase
    endtask

    initial begin
        hsl_t       directed_colours[$];
        idle_mode_t modes[4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        // {lightness, saturation, hue}
        directed_colours = '{
            {16'd0,     16'd0,     16'd0},
            {16'd65535, 16'd0,     16'd12345},
            {16'd40000, 16'd0,     16'd65535},
            {16'd32768, 16'd65535, 16'd0},
            {16'd32767, 16'd65535, 16'd65535},
            {16'd32768, 16'd65535, 16'd10922},
            {16'd32768, 16'd65535, 16'd10923},
            {16'd32767, 16'd65535, 16'd21844},
            {16'd32767, 16'd65535, 16'd21845},
            {16'd32768, 16'd65535, 16'd32767},
            {16'd32768, 16'd65535, 16'd32768},
            {16'd32767, 16'd65535, 16'd43690},
            {16'd32767, 16'd65535, 16'd43691},
            {16'd32768, 16'd65535, 16'd54612},
            {16'd32768, 16'd65535, 16'd54613},
            {16'd0,     16'd65535, 16'd30000},
            {16'd65535, 16'd65535, 16'd30000},
            {16'd1,     16'd1,     16'd0},
            {16'd32767, 16'd1,     16'd5000},
            {16'd65534, 16'd65535, 16'd60000},
            {16'd65535, 16'd65535, 16'd65535},
            {16'd21000, 16'd30000, 16'd50000}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle_mode(IDLE_NONE);
        foreach (directed_colours[i]) send_colour(directed_colours[i]);
        drain_pipeline();

        foreach (modes[m]) begin
            set_idle_mode(modes[m]);
            repeat (PHASE_ITEMS) send_colour(random_colour());
            if (modes[m] == IDLE_SENDER) drain_pipeline();
        end

        // Long output hold-off while the input keeps offering: fill the pipe.
        set_idle_mode(IDLE_NONE);
        hold_request = 1'b1;
        repeat (BURST_ITEMS) send_colour(random_colour());
        s_tvalid <= 1'b0;

        set_idle_mode(IDLE_BOTH);
        while (colour_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (colour_sb.mismatches == 0 && colour_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
